FILE: rtl/ukvt_pkg.sv
`default_nettype none

package ukvt_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ADD  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [1:0]          action;
    logic signed [31:0]  lookup_key;
    logic [31:0]         payload_in;
    logic [2:0]          position_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [2:0]          position_out;
    logic signed [31:0]  key_out;
    logic [31:0]         payload_out;
    logic [3:0]          entry_count;
  } out_item_t;

  // Command broadcast to every cell.
  typedef struct packed {
    cell_op_t            op;
    logic signed [31:0]  key;
    logic [31:0]         pay;
  } cell_ctl_t;

  // Match and read results rippling down the chain.
  typedef struct packed {
    logic                seen;
    logic [IDX_W-1:0]    hit_pos;
    logic signed [31:0]  hit_key;
    logic [31:0]         hit_pay;
    logic                rd_hit;
    logic signed [31:0]  rd_key;
    logic [31:0]         rd_pay;
  } chain_t;

  function automatic logic [2:0] pos3(input logic [IDX_W-1:0] x);
    logic [IDX_W+2:0] w;
    w = {3'b000, x};
    return w[2:0];
  endfunction

  function automatic logic [3:0] cnt4(input logic [CNT_W-1:0] x);
    logic [CNT_W+3:0] w;
    w = {4'b0000, x};
    return w[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ukvt_cell.sv
`default_nettype none

module ukvt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ukvt_pkg::cell_ctl_t           ctl,
  input  logic [ukvt_pkg::IDX_W-1:0]    cell_idx,
  input  logic                          rd_sel,
  input  logic                          prev_valid,
  input  logic                          next_valid,
  input  logic signed [31:0]            next_key,
  input  logic [31:0]                   next_pay,
  input  ukvt_pkg::chain_t              chain_in,
  output ukvt_pkg::chain_t              chain_out,
  output logic                          valid_o,
  output logic signed [31:0]            key_o,
  output logic [31:0]                   pay_o
);

  logic               valid_r, valid_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [31:0]        pay_r, pay_nxt;
  logic               match;

  assign match = valid_r && (key_r == ctl.key);

  always_comb begin
    chain_out = chain_in;
    chain_out.seen = chain_in.seen | match;
    if (match && !chain_in.seen) begin
      chain_out.hit_pos = cell_idx;
      chain_out.hit_key = key_r;
      chain_out.hit_pay = pay_r;
    end
    if (rd_sel && valid_r) begin
      chain_out.rd_hit = 1'b1;
      chain_out.rd_key = key_r;
      chain_out.rd_pay = pay_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    case (ctl.op)
      ukvt_pkg::CELL_ADD: begin
        // first empty slot takes the new entry
        if (!valid_r && prev_valid) begin
          valid_nxt = 1'b1;
          key_nxt   = ctl.key;
          pay_nxt   = ctl.pay;
        end
      end
      ukvt_pkg::CELL_DEL: begin
        // close the gap: every cell at or after the hit takes its neighbour
        if (chain_out.seen) begin
          valid_nxt = next_valid;
          key_nxt   = next_key;
          pay_nxt   = next_pay;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign valid_o = valid_r;
  assign key_o   = key_r;
  assign pay_o   = pay_r;

endmodule

`default_nettype wire

FILE: rtl/unique_key_value_table.sv
`default_nettype none

// Ordered key/value table of CAPACITY (8) entries in insertion order. Raise
// start with an item while busy is low; busy never rises, so one item is
// taken every cycle. The result appears on out_item with out_valid high for
// exactly one cycle, the cycle after the item was taken, and must be
// captured then: there is no way to hold it off. Each item is handled by
// one pass of the key compare ripple along the row of cells, which also
// drives the shift on delete. Entries need no clearing after reset: a
// per-cell valid bit marks the occupied slots.
module unique_key_value_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ukvt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ukvt_pkg::out_item_t out_item
);

  localparam int CAP = ukvt_pkg::CAPACITY;

  logic                          accept;
  logic [ukvt_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          out_valid_r;
  ukvt_pkg::out_item_t           out_item_r, out_item_nxt;
  ukvt_pkg::cell_ctl_t           ctl;
  ukvt_pkg::chain_t              chain_w [CAP+1];
  ukvt_pkg::chain_t              fin;
  logic [CAP-1:0]                valid_w;
  logic signed [31:0]            key_w [CAP];
  logic [31:0]                   pay_w [CAP];
  logic [CAP-1:0]                rd_sel;
  logic                          full;

  // The block is always ready: busy is tied low.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign chain_w[0] = '0;
  assign fin        = chain_w[CAP];
  assign full       = (count_r == ukvt_pkg::CNT_W'(CAP));

  // Decide the cell command: add only when the key is new and a slot is free,
  // delete only when some cell matched.
  always_comb begin
    ctl.key = in_item.lookup_key;
    ctl.pay = in_item.payload_in;
    ctl.op  = ukvt_pkg::CELL_HOLD;
    if (accept) begin
      case (in_item.action)
        ukvt_pkg::ACT_ADD:    if (!fin.seen && !full) ctl.op = ukvt_pkg::CELL_ADD;
        ukvt_pkg::ACT_DELETE: if (fin.seen) ctl.op = ukvt_pkg::CELL_DEL;
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      logic                prev_v;
      logic                next_v;
      logic signed [31:0]  next_k;
      logic [31:0]         next_p;

      if (g == 0) begin : g_head
        assign prev_v = 1'b1;
      end else begin : g_body
        assign prev_v = valid_w[g-1];
      end

      if (g == CAP - 1) begin : g_tail
        assign next_v = 1'b0;
        assign next_k = '0;
        assign next_p = '0;
      end else begin : g_mid
        assign next_v = valid_w[g+1];
        assign next_k = key_w[g+1];
        assign next_p = pay_w[g+1];
      end

      assign rd_sel[g] = ({29'd0, in_item.position_in} == 32'(g));

      ukvt_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cell_idx   (ukvt_pkg::IDX_W'(g)),
        .rd_sel     (rd_sel[g]),
        .prev_valid (prev_v),
        .next_valid (next_v),
        .next_key   (next_k),
        .next_pay   (next_p),
        .chain_in   (chain_w[g]),
        .chain_out  (chain_w[g+1]),
        .valid_o    (valid_w[g]),
        .key_o      (key_w[g]),
        .pay_o      (pay_w[g])
      );
    end
  endgenerate

  // Build the result and the new entry count.
  always_comb begin
    count_nxt    = count_r;
    out_item_nxt = '0;
    case (in_item.action)
      ukvt_pkg::ACT_ADD: begin
        if (fin.seen) begin
          out_item_nxt.status       = ukvt_pkg::ST_DUP;
          out_item_nxt.position_out = ukvt_pkg::pos3(fin.hit_pos);
          out_item_nxt.key_out      = fin.hit_key;
          out_item_nxt.payload_out  = fin.hit_pay;
        end else if (full) begin
          out_item_nxt.status = ukvt_pkg::ST_FULL;
        end else begin
          out_item_nxt.status       = ukvt_pkg::ST_OK;
          out_item_nxt.position_out =
            ukvt_pkg::pos3(count_r[ukvt_pkg::IDX_W-1:0]);
          out_item_nxt.key_out      = in_item.lookup_key;
          out_item_nxt.payload_out  = in_item.payload_in;
          count_nxt                 = count_r + 1'b1;
        end
      end
      ukvt_pkg::ACT_DELETE, ukvt_pkg::ACT_SEARCH: begin
        if (fin.seen) begin
          out_item_nxt.status       = ukvt_pkg::ST_OK;
          out_item_nxt.position_out = ukvt_pkg::pos3(fin.hit_pos);
          out_item_nxt.key_out      = fin.hit_key;
          out_item_nxt.payload_out  = fin.hit_pay;
          if (in_item.action == ukvt_pkg::ACT_DELETE) begin
            count_nxt = count_r - 1'b1;
          end
        end else begin
          out_item_nxt.status = ukvt_pkg::ST_MISSING;
        end
      end
      ukvt_pkg::ACT_READ: begin
        // the selected cell is valid exactly when the position is below the count
        if (fin.rd_hit) begin
          out_item_nxt.status       = ukvt_pkg::ST_OK;
          out_item_nxt.position_out = in_item.position_in;
          out_item_nxt.key_out      = fin.rd_key;
          out_item_nxt.payload_out  = fin.rd_pay;
        end else begin
          out_item_nxt.status = ukvt_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    out_item_nxt.entry_count = ukvt_pkg::cnt4(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks.
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result strobe without an item taken the cycle before");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == 32'(count_r))
    else $error("entry count disagrees with occupied cells");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ukvt_pkg::CNT_W'(CAP))
    else $error("entry count beyond capacity");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == ukvt_pkg::CELL_DEL) |=> (count_r == $past(count_r) - 1'b1))
    else $error("delete did not shrink the table");

endmodule

`default_nettype wire
